// ===== sv/modular_exponentiation_barrett_core_assert.svh =====
// Assertion macros for the modular exponentiation core
`ifndef MODULAR_EXPONENTIATION_BARRETT_CORE_ASSERT_SVH
`define MODULAR_EXPONENTIATION_BARRETT_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define MEB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication with the consequent checked in the next cycle
`define MEB_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== sv/meb_pkg.sv =====
// ----------------------------------------------------------------------------
// meb_pkg
// Shared types and register indexes of the modular exponentiation core.
// ----------------------------------------------------------------------------
package meb_pkg;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FACTOR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BITS    = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_BITLEN, ST_DIV, ST_RED, ST_LOOP,
    ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7,
    ST_M8, ST_M9, ST_M10, ST_M11, ST_M12, ST_M13, ST_M14, ST_M15,
    ST_M16, ST_M17, ST_DONE
  } state_t;
endpackage

// ===== sv/meb_mul32.sv =====
// ----------------------------------------------------------------------------
// meb_mul32
// Registered 32x32 multiplier shared by every product of the core.
// ----------------------------------------------------------------------------
module meb_mul32 (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);
  logic [63:0] p_r;
  // register the product
  always_ff @(posedge clk) begin
    p_r <= 64'(a) * 64'(b);
  end
  assign p = p_r;
endmodule

// ===== sv/modular_exponentiation_barrett_core.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation_barrett_core
// base^exponent mod modulus by right-to-left square-and-multiply with Barrett.
// Exponent 0/1 or a zero modulus go straight to done from the bit-length step; otherwise
//   the bit-length scan, the factor division (when derived), the base reduce and a square
//   per exponent bit (plus a multiply when set) follow, on one shared 32x32 multiplier.
// Throughput: one word at a time; busy stays high until done pulses; no output stall.
// Reset: synchronous active-low; modulus 3, factor and bit count 0, idle.
// ----------------------------------------------------------------------------
module modular_exponentiation_barrett_core #(
  parameter int unsigned DATA_BITS = 64
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic [63:0] in_base_value,
  input  logic [63:0] in_exponent_value,
  output logic done,
  output logic [63:0] out_power_result,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [meb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0] cfg_data
);
  import meb_pkg::*;

  localparam logic [63:0] MASK = {64{1'b1}} >> (64 - DATA_BITS);

  state_t st_r, st_nxt;
  logic [61:0]  mod_r;
  logic [63:0]  fac_r;
  logic [5:0]   bits_r;
  logic [63:0]  res_r, base_r, exp_r, f_r, out_r;
  logic [6:0]   k_r, cnt_r;
  logic [63:0]  rem_r, quo_r;
  logic         done_r, sel_r;
  // multiply operands and accumulators
  logic [63:0]  ma_r, mb_r, prod_r, qm_r;
  logic [127:0] acc_r, t_r;
  logic [31:0]  mul_a, mul_b;
  logic [63:0]  mul_p;

  meb_mul32 u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  assign busy = (st_r != ST_IDLE);
  assign cfg_ready = !busy;
  assign done = done_r;
  assign out_power_result = out_r;

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:   if (start) st_nxt = ST_BITLEN;
      ST_BITLEN: if (rem_r == 64'd0 || exp_r <= 64'd1)
                   st_nxt = (exp_r <= 64'd1 || mod_r == 62'd0) ? ST_DONE :
                            (fac_r != 64'd0) ? ST_RED : ST_DIV;
      ST_DIV:    if (cnt_r == 7'd127) st_nxt = ST_RED;
      ST_RED:    if (cnt_r == 7'd63) st_nxt = ST_LOOP;
      ST_LOOP:   st_nxt = (exp_r == 64'd0) ? ST_DONE : ST_M0;
      ST_M0:  st_nxt = ST_M1;   ST_M1:  st_nxt = ST_M2;
      ST_M2:  st_nxt = ST_M3;   ST_M3:  st_nxt = ST_M4;
      ST_M4:  st_nxt = ST_M5;   ST_M5:  st_nxt = ST_M6;
      ST_M6:  st_nxt = ST_M7;   ST_M7:  st_nxt = ST_M8;
      ST_M8:  st_nxt = ST_M9;   ST_M9:  st_nxt = ST_M10;
      ST_M10: st_nxt = ST_M11;  ST_M11: st_nxt = ST_M12;
      ST_M12: st_nxt = ST_M13;  ST_M13: st_nxt = ST_M14;
      ST_M14: st_nxt = ST_M15;  ST_M15: st_nxt = ST_M16;
      ST_M16: st_nxt = ST_M17;
      ST_M17: st_nxt = (sel_r || !exp_r[0]) ? ST_LOOP : ST_M0;
      ST_DONE: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  logic [5:0]   sh_lo;
  logic [63:0]  q_sh;
  logic [63:0]  r_sub, r_fix;
  logic [6:0]   k_use;
  logic [63:0]  rem_sh;
  assign sh_lo = 6'(k_r - 7'd2);
  assign q_sh  = 64'(acc_r >> (k_r + 7'd2));
  assign rem_sh = {rem_r[62:0], (7'(cnt_r ^ 7'd127) == {k_r[5:0], 1'b0})};
  assign k_use = (bits_r != 6'd0) ? {1'b0, bits_r} : cnt_r;

  // pick multiplier operands: M0-M3 a*b, M5-M11 shifted*f, M13-M15 quotient*m
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (st_r)
      ST_M0:  begin mul_a = ma_r[31:0];  mul_b = mb_r[31:0];  end
      ST_M1:  begin mul_a = ma_r[31:0];  mul_b = mb_r[63:32]; end
      ST_M2:  begin mul_a = ma_r[63:32]; mul_b = mb_r[31:0];  end
      ST_M3:  begin mul_a = ma_r[63:32]; mul_b = mb_r[63:32]; end
      ST_M5:  begin mul_a = t_r[31:0];   mul_b = f_r[31:0];   end
      ST_M6:  begin mul_a = t_r[31:0];   mul_b = f_r[63:32];  end
      ST_M7:  begin mul_a = t_r[63:32];  mul_b = f_r[31:0];   end
      ST_M8:  begin mul_a = t_r[63:32];  mul_b = f_r[63:32];  end
      ST_M9:  begin mul_a = t_r[95:64];  mul_b = f_r[31:0];   end
      ST_M10: begin mul_a = t_r[95:64];  mul_b = f_r[63:32];  end
      ST_M11: begin mul_a = t_r[127:96]; mul_b = f_r[31:0];   end
      ST_M13: begin mul_a = q_sh[31:0];  mul_b = mod_r[31:0]; end
      ST_M14: begin mul_a = q_sh[31:0];  mul_b = {2'b00, mod_r[61:32]}; end
      ST_M15: begin mul_a = q_sh[63:32]; mul_b = mod_r[31:0]; end
      default: ;
    endcase
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      mod_r <= 62'd3;
      fac_r <= '0;
      bits_r <= '0;
      done_r <= 1'b0;
      res_r <= '0; base_r <= '0; exp_r <= '0; f_r <= '0; k_r <= '0;
    end else begin
      st_r <= st_nxt;
      done_r <= 1'b0;
      // take a configuration word
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MODULUS: mod_r <= cfg_data[61:0];
          REG_FACTOR:  fac_r <= cfg_data;
          REG_BITS:    bits_r <= cfg_data[5:0];
          default: ;
        endcase
      end
      unique case (st_r)
        ST_IDLE: if (start) begin
          base_r <= in_base_value & MASK;
          exp_r  <= in_exponent_value & MASK;
          cnt_r  <= '0;
          rem_r  <= {2'b00, mod_r};
        end
        // bit length by shifting the modulus down
        ST_BITLEN: begin
          if (rem_r != 64'd0 && exp_r > 64'd1) begin
            rem_r <= rem_r >> 1;
            cnt_r <= cnt_r + 7'd1;
          end else begin
            k_r <= (k_use < 7'd2) ? 7'd2 : k_use;
            f_r <= fac_r;
            cnt_r <= '0;
            rem_r <= '0;
            quo_r <= '0;
            if (exp_r == 64'd0) out_r <= 64'd1;
            else if (exp_r == 64'd1) out_r <= base_r;
            else out_r <= '0;
          end
        end
        // restoring division for the factor
        ST_DIV: begin
          if (rem_sh >= {2'b00, mod_r}) begin
            rem_r <= rem_sh - {2'b00, mod_r};
            quo_r <= {quo_r[62:0], 1'b1};
            f_r   <= {quo_r[62:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            quo_r <= {quo_r[62:0], 1'b0};
            f_r   <= {quo_r[62:0], 1'b0};
          end
          cnt_r <= (cnt_r == 7'd127) ? 7'd0 : cnt_r + 7'd1;
          if (cnt_r == 7'd127) rem_r <= '0;
        end
        // base mod modulus, one bit a cycle
        ST_RED: begin
          if ({rem_r[62:0], base_r[63]} >= {2'b00, mod_r})
            rem_r <= {rem_r[62:0], base_r[63]} - {2'b00, mod_r};
          else
            rem_r <= {rem_r[62:0], base_r[63]};
          base_r <= {base_r[62:0], 1'b0};
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'd63) begin
            base_r <= ({rem_r[62:0], base_r[63]} >= {2'b00, mod_r}) ?
                      {rem_r[62:0], base_r[63]} - {2'b00, mod_r} :
                      {rem_r[62:0], base_r[63]};
            res_r <= 64'd1;
          end
        end
        // choose multiply or square
        ST_LOOP: begin
          if (exp_r == 64'd0) out_r <= res_r & MASK;
          else begin
            sel_r <= !exp_r[0];
            ma_r  <= exp_r[0] ? res_r : base_r;
            mb_r  <= base_r;
          end
          acc_r <= '0;
        end
        // full product a*b
        ST_M1:  acc_r <= 128'(mul_p);
        ST_M2:  acc_r <= acc_r + (128'(mul_p) << 32);
        ST_M3:  acc_r <= acc_r + (128'(mul_p) << 32);
        ST_M4: begin
          prod_r <= acc_r[63:0];
          t_r    <= (acc_r + (128'(mul_p) << 64)) >> sh_lo;
        end
        // shifted product times factor, kept to 128 bits
        ST_M6:  acc_r <= 128'(mul_p);
        ST_M7:  acc_r <= acc_r + (128'(mul_p) << 32);
        ST_M8:  acc_r <= acc_r + (128'(mul_p) << 32);
        ST_M9:  acc_r <= acc_r + (128'(mul_p) << 64);
        ST_M10: acc_r <= acc_r + (128'(mul_p) << 64);
        ST_M11: acc_r <= acc_r + (128'(mul_p) << 96);
        ST_M12: acc_r <= acc_r + (128'(mul_p) << 96);
        // quotient times modulus, low 64 bits only
        ST_M14: qm_r <= mul_p;
        ST_M15: qm_r <= qm_r + {mul_p[31:0], 32'd0};
        ST_M16: qm_r <= qm_r + {mul_p[31:0], 32'd0};
        ST_M17: begin
          if (sel_r) begin
            base_r <= r_fix;
            exp_r  <= exp_r >> 1;
          end else begin
            res_r <= r_fix;
            sel_r <= 1'b1;
            ma_r  <= base_r;
            mb_r  <= base_r;
          end
          acc_r <= '0;
        end
        ST_DONE: done_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // remainder with one conditional subtraction
  assign r_sub = prod_r - qm_r;
  assign r_fix = (r_sub >= {2'b00, mod_r}) ? r_sub - {2'b00, mod_r} : r_sub;

  `include "modular_exponentiation_barrett_core_assert.svh"
  `MEB_ASSERT_NXT(a_done_after, st_r == ST_DONE, done, "done missing after finish")
  `MEB_ASSERT_IMP(a_no_cfg_busy, busy, !cfg_ready, "config taken while busy")
  `MEB_ASSERT_NXT(a_start_busy, start && !busy, busy, "start not taken")
endmodule
